// File: rtl/fhf_pkg.sv
// Shared constants, types and state encodings for the heavy-flow vote table.
`timescale 1ns / 1ps
package fhf_pkg;

  // Geometry of the filter and the record table.
  localparam int FILTER_ROWS = 3;
  localparam int FILTER_COLS = 1024;
  localparam int RECORD_ROWS = 256;
  localparam int RECORD_COLS = 4;
  localparam int NUM_CAND    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam int FCOL_W  = $clog2(FILTER_COLS);
  localparam int ROW_W   = $clog2(RECORD_ROWS);
  localparam int COL_W   = $clog2(RECORD_COLS);
  localparam int CAND_W  = $clog2(NUM_CAND);
  localparam int SCAN_W  = CAND_W + COL_W;
  localparam int TAB_W   = ROW_W + COL_W;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  // Field widths.
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int FP_W    = 32;
  localparam int HASH_W  = 32;
  localparam int ECNT_W  = 32;
  localparam int VOTE_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int PROD_W  = CFG_W + ECNT_W;
  localparam int BYTE_W  = 8;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT        = 2'd2;
  localparam logic [CFG_W-1:0] FILTER_THRESHOLD_RST  = 16'd3;
  localparam logic [CFG_W-1:0] REFRESH_THRESHOLD_RST = 16'd1536;
  localparam logic [CFG_W-1:0] VOTE_LIMIT_RST        = 16'd8;

  // Item modes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    OUT_QUERY      = 3'd0,
    OUT_HIT        = 3'd1,
    OUT_PLACED     = 3'd2,
    OUT_EVICTED    = 3'd3,
    OUT_NOT_PLACED = 3'd4,
    OUT_BLOCKED    = 3'd5
  } outcome_t;

  typedef struct packed {
    logic              mode;
    logic [9:0]        filter_index_a;
    logic [9:0]        filter_index_b;
    logic [9:0]        filter_index_c;
    logic [HASH_W-1:0] bucket_hash;
    logic [FP_W-1:0]   fingerprint;
  } item_t;

  typedef struct packed {
    logic [ECNT_W-1:0] flow_count;
    logic              passed_filter;
    outcome_t          outcome;
    logic              filter_refreshed;
  } result_t;

  // Classified item handed from the filter front end to the table engine.
  typedef struct packed {
    logic              mode;
    logic [HASH_W-1:0] bucket_hash;
    logic [FP_W-1:0]   fingerprint;
    logic              passed;
    logic              refreshed;
  } job_t;

  typedef struct packed {
    logic [CFG_W-1:0] filter_threshold;
    logic [CFG_W-1:0] refresh_threshold;
    logic [CFG_W-1:0] vote_limit;
  } cfg_t;

  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] count;
  } cell_t;

  typedef struct packed {
    logic [FP_W-1:0]   fp;
    logic [ECNT_W-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    F_CLEAR,
    F_IDLE,
    F_EVAL,
    F_SWEEP_RD,
    F_SWEEP_WR
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CHK,
    B_VOTE_RD,
    B_VOTE_UPD,
    B_MUL,
    B_CMP,
    B_EVICT
  } back_state_t;

endpackage

// File: rtl/fhf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fhf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fhf_front.sv
// Filter front end: counting filter, pass decision and flag refresh sweep.
`timescale 1ns / 1ps
module fhf_front (
  input  logic           clk,
  input  logic           rst,
  input  fhf_pkg::cfg_t  cfg,
  input  logic           item_valid,
  output logic           item_stall,
  input  fhf_pkg::item_t item,
  input  logic           q_full,
  output logic           q_push,
  output fhf_pkg::job_t  q_job
);

  fhf_pkg::front_state_t state, state_next;
  logic [fhf_pkg::FCOL_W-1:0]  sweep_addr;
  logic [fhf_pkg::TOTAL_W-1:0] total;
  fhf_pkg::item_t              item_q;

  fhf_pkg::cell_t              rd     [fhf_pkg::FILTER_ROWS];
  fhf_pkg::cell_t              wdata  [fhf_pkg::FILTER_ROWS];
  logic [fhf_pkg::FCOL_W-1:0]  raddr  [fhf_pkg::FILTER_ROWS];
  logic [fhf_pkg::FCOL_W-1:0]  waddr  [fhf_pkg::FILTER_ROWS];
  logic [fhf_pkg::FCOL_W-1:0]  in_col [fhf_pkg::FILTER_ROWS];
  logic [fhf_pkg::FCOL_W-1:0]  q_col  [fhf_pkg::FILTER_ROWS];
  logic                        we;
  logic                        accept;
  logic                        sweep_last;

  logic [fhf_pkg::CNT_W-1:0]   minv;
  logic                        all_flags;
  logic                        below;
  logic                        pass;
  logic                        refresh;
  logic [fhf_pkg::FILTER_ROWS-1:0] inc;
  logic [1:0]                  add;
  logic [fhf_pkg::TOTAL_W-1:0] total_sum;
  logic [fhf_pkg::CNT_W:0]     thr_ext;
  logic [fhf_pkg::CNT_W:0]     c0_up;
  logic [fhf_pkg::CNT_W:0]     c1_up;

  assign in_col[0] = item.filter_index_a[fhf_pkg::FCOL_W-1:0];
  assign in_col[1] = item.filter_index_b[fhf_pkg::FCOL_W-1:0];
  assign in_col[2] = item.filter_index_c[fhf_pkg::FCOL_W-1:0];
  assign q_col[0]  = item_q.filter_index_a[fhf_pkg::FCOL_W-1:0];
  assign q_col[1]  = item_q.filter_index_b[fhf_pkg::FCOL_W-1:0];
  assign q_col[2]  = item_q.filter_index_c[fhf_pkg::FCOL_W-1:0];

  // An item is taken only when idle and the queue has room for its job.
  assign item_stall = !(state == fhf_pkg::F_IDLE && !q_full);
  assign accept     = item_valid && !item_stall;
  assign sweep_last = sweep_addr == fhf_pkg::FCOL_W'(fhf_pkg::FILTER_COLS - 1);

  // One counter memory per filter row so the three cells are read together.
  for (genvar g = 0; g < fhf_pkg::FILTER_ROWS; g++) begin : g_row
    fhf_ram #(
      .WIDTH($bits(fhf_pkg::cell_t)),
      .DEPTH(fhf_pkg::FILTER_COLS)
    ) u_row (
      .clk   (clk),
      .we    (we),
      .waddr (waddr[g]),
      .wdata (wdata[g]),
      .raddr (raddr[g]),
      .rdata (rd[g])
    );
  end

  // Minimum, pass decision and equal-minimum increment selection.
  always_comb begin
    minv      = cfg.filter_threshold;
    all_flags = 1'b1;
    for (int g = 0; g < fhf_pkg::FILTER_ROWS; g++) begin
      if (rd[g].count < minv) begin
        minv = rd[g].count;
      end
      if (!rd[g].flag) begin
        all_flags = 1'b0;
      end
    end
    below   = minv < cfg.filter_threshold;
    pass    = !(below && !all_flags);
    thr_ext = {1'b0, cfg.filter_threshold};
    c0_up   = {1'b0, rd[0].count} + 1'b1;
    c1_up   = {1'b0, rd[1].count} + 1'b1;
    inc     = '0;
    add     = 2'd0;
    if (below) begin
      if (rd[0].count == rd[1].count && rd[1].count == rd[2].count) begin
        inc = 3'b111;
        if (c0_up == thr_ext) add = 2'd3;
      end else if (rd[0].count == rd[1].count && rd[1].count == minv) begin
        inc = 3'b011;
        if (c0_up == thr_ext) add = 2'd2;
      end else if (rd[1].count == rd[2].count && rd[2].count == minv) begin
        inc = 3'b110;
        if (c1_up == thr_ext) add = 2'd2;
      end else if (rd[0].count == rd[2].count && rd[2].count == minv) begin
        inc = 3'b101;
        if (c0_up == thr_ext) add = 2'd2;
      end else if (rd[0].count == minv) begin
        inc = 3'b001;
      end else if (rd[1].count == minv) begin
        inc = 3'b010;
      end else begin
        inc = 3'b100;
      end
    end
    total_sum = total + fhf_pkg::TOTAL_W'(add);
    refresh   = total_sum >= fhf_pkg::TOTAL_W'(cfg.refresh_threshold);
  end

  // Memory port steering for lookup, update, clear and refresh sweep.
  always_comb begin
    we = state == fhf_pkg::F_CLEAR || state == fhf_pkg::F_EVAL ||
         state == fhf_pkg::F_SWEEP_WR;
    for (int g = 0; g < fhf_pkg::FILTER_ROWS; g++) begin
      raddr[g] = (state == fhf_pkg::F_IDLE) ? in_col[g] : sweep_addr;
      waddr[g] = (state == fhf_pkg::F_EVAL) ? q_col[g] : sweep_addr;
      case (state)
        fhf_pkg::F_EVAL: begin
          wdata[g] = '{flag: rd[g].flag,
                       count: rd[g].count + fhf_pkg::CNT_W'(inc[g])};
        end
        fhf_pkg::F_SWEEP_WR: begin
          wdata[g] = '{flag: rd[g].count >= cfg.filter_threshold, count: '0};
        end
        default: begin
          wdata[g] = '0;
        end
      endcase
    end
  end

  // Queries go straight to the queue; inserts after their filter update.
  always_comb begin
    q_push = (accept && item.mode == fhf_pkg::MODE_QUERY) || state == fhf_pkg::F_EVAL;
    if (state == fhf_pkg::F_EVAL) begin
      q_job = '{mode: item_q.mode, bucket_hash: item_q.bucket_hash,
                fingerprint: item_q.fingerprint, passed: pass, refreshed: refresh};
    end else begin
      q_job = '{mode: item.mode, bucket_hash: item.bucket_hash,
                fingerprint: item.fingerprint, passed: 1'b0, refreshed: 1'b0};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fhf_pkg::F_CLEAR: begin
        if (sweep_last) state_next = fhf_pkg::F_IDLE;
      end
      fhf_pkg::F_IDLE: begin
        if (accept && item.mode == fhf_pkg::MODE_INSERT) state_next = fhf_pkg::F_EVAL;
      end
      fhf_pkg::F_EVAL: begin
        state_next = refresh ? fhf_pkg::F_SWEEP_RD : fhf_pkg::F_IDLE;
      end
      fhf_pkg::F_SWEEP_RD: begin
        state_next = fhf_pkg::F_SWEEP_WR;
      end
      fhf_pkg::F_SWEEP_WR: begin
        state_next = sweep_last ? fhf_pkg::F_IDLE : fhf_pkg::F_SWEEP_RD;
      end
      default: begin
        state_next = fhf_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fhf_pkg::F_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sweep address, full-cell total and the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      total      <= '0;
    end else begin
      if (state == fhf_pkg::F_CLEAR || state == fhf_pkg::F_SWEEP_WR) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (state == fhf_pkg::F_EVAL) begin
        total <= refresh ? '0 : total_sum;
      end
    end
    if (accept) begin
      item_q <= item;
    end
  end

endmodule

// File: rtl/fhf_queue.sv
// Short job queue between the filter front end and the table engine.
`timescale 1ns / 1ps
module fhf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fhf_pkg::job_t job_in,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output fhf_pkg::job_t job_out
);

  fhf_pkg::job_t               slot [fhf_pkg::QUEUE_DEPTH];
  logic [fhf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [fhf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [fhf_pkg::QPTR_W:0]    fill;

  assign full    = fill == (fhf_pkg::QPTR_W + 1)'(fhf_pkg::QUEUE_DEPTH);
  assign valid   = fill != '0;
  assign job_out = slot[rd_ptr];

  // Ring pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (fhf_pkg::QPTR_W + 1)'(push) - (fhf_pkg::QPTR_W + 1)'(pop);
    end
    if (push) begin
      slot[wr_ptr] <= job_in;
    end
  end

endmodule

// File: rtl/fhf_back.sv
// Table engine: lookup, first-empty placement and vote-based replacement.
`timescale 1ns / 1ps
module fhf_back (
  input  logic             clk,
  input  logic             rst,
  input  fhf_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  fhf_pkg::job_t    q_job,
  output logic             result_valid,
  input  logic             result_stall,
  output fhf_pkg::result_t result
);

  localparam int NSCAN = fhf_pkg::NUM_CAND * fhf_pkg::RECORD_COLS;

  fhf_pkg::back_state_t state, state_next;
  logic [fhf_pkg::TAB_W-1:0]  clr_addr;
  fhf_pkg::job_t              job;
  logic [fhf_pkg::SCAN_W-1:0] idx;
  logic [fhf_pkg::SCAN_W-1:0] idx_inc;
  logic [fhf_pkg::ECNT_W-1:0] cnt_buf [NSCAN];
  logic [fhf_pkg::VOTE_W-1:0] vote_cur;
  logic [fhf_pkg::PROD_W-1:0] prod;
  logic                       best_found;
  logic [fhf_pkg::ECNT_W-1:0] best_cnt;
  logic [fhf_pkg::SCAN_W-1:0] best_idx;

  fhf_pkg::entry_t            t_rd;
  fhf_pkg::entry_t            t_wd;
  logic                       t_we;
  logic [fhf_pkg::TAB_W-1:0]  t_raddr;
  logic [fhf_pkg::TAB_W-1:0]  t_waddr;
  logic [fhf_pkg::VOTE_W-1:0] v_rd;
  logic [fhf_pkg::VOTE_W-1:0] v_wd;
  logic [fhf_pkg::VOTE_W-1:0] v_inc;
  logic                       v_we;
  logic [fhf_pkg::ROW_W-1:0]  v_raddr;
  logic [fhf_pkg::ROW_W-1:0]  v_waddr;

  logic                       start;
  logic                       quick;
  fhf_pkg::result_t           quick_result;
  logic                       is_query;
  logic                       match;
  logic                       empty;
  logic                       scan_last;
  logic                       col_last;
  logic                       cand_last;
  logic                       qualify;
  logic                       better;

  // Candidate row from one byte of the hash, most significant byte first.
  function automatic logic [fhf_pkg::ROW_W-1:0] cand_row(
    input logic [fhf_pkg::HASH_W-1:0] h,
    input logic [fhf_pkg::CAND_W-1:0] c
  );
    logic [fhf_pkg::BYTE_W-1:0] b;
    b = h[fhf_pkg::BYTE_W * (fhf_pkg::NUM_CAND - 1 - int'(c)) +: fhf_pkg::BYTE_W];
    return b[fhf_pkg::ROW_W-1:0];
  endfunction

  function automatic logic [fhf_pkg::TAB_W-1:0] addr_of(
    input logic [fhf_pkg::HASH_W-1:0] h,
    input logic [fhf_pkg::SCAN_W-1:0] s
  );
    return {cand_row(h, s[fhf_pkg::SCAN_W-1:fhf_pkg::COL_W]), s[fhf_pkg::COL_W-1:0]};
  endfunction

  fhf_ram #(
    .WIDTH($bits(fhf_pkg::entry_t)),
    .DEPTH(fhf_pkg::RECORD_ROWS * fhf_pkg::RECORD_COLS)
  ) u_entries (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wd),
    .raddr (t_raddr),
    .rdata (t_rd)
  );

  fhf_ram #(
    .WIDTH(fhf_pkg::VOTE_W),
    .DEPTH(fhf_pkg::RECORD_ROWS)
  ) u_votes (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wd),
    .raddr (v_raddr),
    .rdata (v_rd)
  );

  // Status of the current scan step.
  assign idx_inc   = idx + 1'b1;
  assign is_query  = job.mode == fhf_pkg::MODE_QUERY;
  assign match     = t_rd.fp == job.fingerprint;
  assign empty     = t_rd.fp == '0;
  assign scan_last = idx == fhf_pkg::SCAN_W'(NSCAN - 1);
  assign col_last  = idx[fhf_pkg::COL_W-1:0] == fhf_pkg::COL_W'(fhf_pkg::RECORD_COLS - 1);
  assign cand_last = idx[fhf_pkg::SCAN_W-1:fhf_pkg::COL_W] ==
                     fhf_pkg::CAND_W'(fhf_pkg::NUM_CAND - 1);
  assign v_inc     = (v_rd == '1) ? v_rd : v_rd + 1'b1;
  assign qualify   = fhf_pkg::PROD_W'(vote_cur) >= prod;
  assign better    = !best_found || cnt_buf[idx] < best_cnt;

  // Items that need no table access finish straight from the queue.
  assign start = state == fhf_pkg::B_IDLE && q_valid && !result_valid;
  assign q_pop = start;
  always_comb begin
    if (q_job.mode == fhf_pkg::MODE_QUERY) begin
      quick        = q_job.fingerprint == '0;
      quick_result = '{flow_count: '0, passed_filter: 1'b0,
                       outcome: fhf_pkg::OUT_QUERY, filter_refreshed: 1'b0};
    end else if (!q_job.passed) begin
      quick        = 1'b1;
      quick_result = '{flow_count: '0, passed_filter: 1'b0,
                       outcome: fhf_pkg::OUT_BLOCKED, filter_refreshed: q_job.refreshed};
    end else begin
      quick        = q_job.fingerprint == '0;
      quick_result = '{flow_count: '0, passed_filter: 1'b1,
                       outcome: fhf_pkg::OUT_NOT_PLACED, filter_refreshed: q_job.refreshed};
    end
  end

  // Memory port steering.
  always_comb begin
    t_raddr = (state == fhf_pkg::B_SCAN_CHK) ? addr_of(job.bucket_hash, idx_inc)
                                             : addr_of(job.bucket_hash, idx);
    v_raddr = cand_row(job.bucket_hash, idx[fhf_pkg::SCAN_W-1:fhf_pkg::COL_W]);
    t_we    = 1'b0;
    t_waddr = addr_of(job.bucket_hash, idx);
    t_wd    = '{fp: job.fingerprint, count: fhf_pkg::ECNT_W'(1)};
    v_we    = 1'b0;
    v_waddr = v_raddr;
    v_wd    = v_inc;
    case (state)
      fhf_pkg::B_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_addr;
        t_wd    = '0;
        v_we    = 1'b1;
        v_waddr = clr_addr[fhf_pkg::TAB_W-1 -: fhf_pkg::ROW_W];
        v_wd    = '0;
      end
      fhf_pkg::B_SCAN_CHK: begin
        t_we = !is_query && (match || empty);
        if (match) begin
          t_wd = '{fp: t_rd.fp,
                   count: (t_rd.count == '1) ? t_rd.count : t_rd.count + 1'b1};
        end
      end
      fhf_pkg::B_VOTE_UPD: begin
        v_we = 1'b1;
      end
      fhf_pkg::B_EVICT: begin
        t_we    = best_found;
        t_waddr = addr_of(job.bucket_hash, best_idx);
        v_we    = best_found;
        v_waddr = cand_row(job.bucket_hash, best_idx[fhf_pkg::SCAN_W-1:fhf_pkg::COL_W]);
        v_wd    = '0;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fhf_pkg::B_CLEAR: begin
        if (clr_addr == '1) state_next = fhf_pkg::B_IDLE;
      end
      fhf_pkg::B_IDLE: begin
        if (start && !quick) state_next = fhf_pkg::B_SCAN_RD;
      end
      fhf_pkg::B_SCAN_RD: begin
        state_next = fhf_pkg::B_SCAN_CHK;
      end
      fhf_pkg::B_SCAN_CHK: begin
        if (is_query) begin
          if (match || scan_last) state_next = fhf_pkg::B_IDLE;
        end else if (match || empty) begin
          state_next = fhf_pkg::B_IDLE;
        end else if (scan_last) begin
          state_next = fhf_pkg::B_VOTE_RD;
        end
      end
      fhf_pkg::B_VOTE_RD: begin
        state_next = fhf_pkg::B_VOTE_UPD;
      end
      fhf_pkg::B_VOTE_UPD: begin
        state_next = fhf_pkg::B_MUL;
      end
      fhf_pkg::B_MUL: begin
        state_next = fhf_pkg::B_CMP;
      end
      fhf_pkg::B_CMP: begin
        if (col_last) begin
          state_next = cand_last ? fhf_pkg::B_EVICT : fhf_pkg::B_VOTE_RD;
        end else begin
          state_next = fhf_pkg::B_MUL;
        end
      end
      fhf_pkg::B_EVICT: begin
        state_next = fhf_pkg::B_IDLE;
      end
      default: begin
        state_next = fhf_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fhf_pkg::B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Scan, vote bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      result_valid <= 1'b0;
      best_found   <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        fhf_pkg::B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        fhf_pkg::B_IDLE: begin
          if (start) begin
            job        <= q_job;
            idx        <= '0;
            best_found <= 1'b0;
            if (quick) begin
              result_valid <= 1'b1;
              result       <= quick_result;
            end
          end
        end
        fhf_pkg::B_SCAN_CHK: begin
          cnt_buf[idx] <= t_rd.count;
          idx          <= idx_inc;
          if (is_query) begin
            if (match || scan_last) begin
              result_valid <= 1'b1;
              result <= '{flow_count: match ? t_rd.count : '0, passed_filter: 1'b0,
                          outcome: fhf_pkg::OUT_QUERY, filter_refreshed: 1'b0};
            end
          end else if (match || empty) begin
            result_valid <= 1'b1;
            result <= '{flow_count: '0, passed_filter: 1'b1,
                        outcome: match ? fhf_pkg::OUT_HIT : fhf_pkg::OUT_PLACED,
                        filter_refreshed: job.refreshed};
          end
        end
        fhf_pkg::B_VOTE_UPD: begin
          vote_cur <= v_inc;
        end
        fhf_pkg::B_MUL: begin
          prod <= cfg.vote_limit * cnt_buf[idx];
        end
        fhf_pkg::B_CMP: begin
          idx <= idx_inc;
          if (qualify && better) begin
            best_found <= 1'b1;
            best_cnt   <= cnt_buf[idx];
            best_idx   <= idx;
          end
        end
        fhf_pkg::B_EVICT: begin
          result_valid <= 1'b1;
          result <= '{flow_count: '0, passed_filter: 1'b1,
                      outcome: best_found ? fhf_pkg::OUT_EVICTED : fhf_pkg::OUT_NOT_PLACED,
                      filter_refreshed: job.refreshed};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/filtered_heavy_flow_vote_table.sv
// Heavy-flow recorder: three-row counting filter feeding a vote replacement table.
// Front end: queries are queued at once, inserts after their filter update; a refresh sweep follows.
// Table engine: items without table access skip it; others scan sixteen entries, and an insert
// without a slot reads the four vote rows (one multiply per entry); a 2-deep queue decouples.
// Reset clears the filter and the table in a pass over every address with item_stall held high.
`timescale 1ns / 1ps
module filtered_heavy_flow_vote_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  fhf_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output fhf_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [fhf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fhf_pkg::CFG_W-1:0]       cfg_data
);

  fhf_pkg::cfg_t cfg;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  fhf_pkg::job_t q_in;
  fhf_pkg::job_t q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{filter_threshold:  fhf_pkg::FILTER_THRESHOLD_RST,
               refresh_threshold: fhf_pkg::REFRESH_THRESHOLD_RST,
               vote_limit:        fhf_pkg::VOTE_LIMIT_RST};
    end else if (cfg_write) begin
      case (cfg_index)
        fhf_pkg::CFG_FILTER_THRESHOLD:  cfg.filter_threshold  <= cfg_data;
        fhf_pkg::CFG_REFRESH_THRESHOLD: cfg.refresh_threshold <= cfg_data;
        fhf_pkg::CFG_VOTE_LIMIT:        cfg.vote_limit        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fhf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_in)
  );

  fhf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (q_in),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .job_out (q_out)
  );

  fhf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_job        (q_out),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("job queue written while full");

  a_query_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.outcome == fhf_pkg::OUT_QUERY |->
      !result.passed_filter && !result.filter_refreshed)
    else $error("query item reports filter activity");

  a_pass_outcome: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.passed_filter |->
      result.outcome == fhf_pkg::OUT_HIT || result.outcome == fhf_pkg::OUT_PLACED ||
      result.outcome == fhf_pkg::OUT_EVICTED || result.outcome == fhf_pkg::OUT_NOT_PLACED)
    else $error("passed item carries a non-table outcome");
`endif

endmodule
